### src/gocs_pkg.sv
`timescale 1ns / 1ps

package gocs_pkg;

  localparam int RAW_W   = 16;
  localparam int RATE_W  = 21;
  localparam int SUM_W   = 26;
  localparam int ALPHA_W = 17;
  localparam int LIM_W   = 16;
  localparam int MA_W    = 18;
  localparam int MB_W    = 23;
  localparam int P_W     = MA_W + MB_W;
  localparam int NUM_AX  = 3;
  localparam int AX_W    = 2;

  typedef logic signed [RATE_W-1:0] rate_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic signed [MA_W-1:0]   mul_a_t;
  typedef logic signed [MB_W-1:0]   mul_b_t;
  typedef logic signed [P_W-1:0]    prod_t;
  typedef logic [AX_W-1:0]          axis_t;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'd65536;
  localparam logic [ALPHA_W-1:0] ALPHA_RST = 17'd6554;
  localparam logic [LIM_W-1:0]   LIM_RST   = 16'd448;
  localparam mul_a_t             SCALE_MUL = 18'sd4559;
  localparam rate_t              RATE_MAX  = 21'sh0FFFFF;
  localparam rate_t              RATE_MIN  = 21'sh100000;
  localparam axis_t              AX_FIRST  = 2'd0;
  localparam axis_t              AX_LAST   = 2'd2;

  localparam logic REG_ALPHA = 1'b0;
  localparam logic REG_LIMIT = 1'b1;

endpackage

### src/gocs_mul.sv
`timescale 1ns / 1ps

module gocs_mul (
  input  logic            clk,
  input  gocs_pkg::mul_a_t a,
  input  gocs_pkg::mul_b_t b,
  output gocs_pkg::prod_t  p_r
);
  import gocs_pkg::*;

  prod_t p_nxt;

  assign p_nxt = P_W'(a) * P_W'(b);

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
  end

endmodule

### src/gocs_rdiv.sv
`timescale 1ns / 1ps

module gocs_rdiv #(
  parameter int DIVISOR = 25
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  gocs_pkg::sum_t  dividend,
  output logic            done_r,
  output gocs_pkg::rate_t quot_r
);
  import gocs_pkg::*;

  localparam int MAG_W  = SUM_W - 1;
  localparam int K_SH   = MAG_W + $clog2(DIVISOR);
  localparam int PROD_W = MAG_W + K_SH + 1;
  localparam longint RECIP_L =
      ((longint'(1) << K_SH) + longint'(DIVISOR - 1)) / longint'(DIVISOR);
  localparam logic [K_SH:0]    RECIP = (K_SH + 1)'(RECIP_L);
  localparam logic [MAG_W-1:0] HALF  = MAG_W'(DIVISOR / 2);

  logic              ld_r, ld_nxt;
  logic              mul_r, mul_nxt;
  logic              done_nxt;
  logic              neg_r, neg_nxt;
  logic [MAG_W-1:0]  mag_r, mag_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  rate_t             quot_nxt;
  sum_t              abs_w;
  sum_t              qs_w;

  always_comb begin
    abs_w    = dividend[SUM_W-1] ? -dividend : dividend;
    qs_w     = prod_r[PROD_W-1:K_SH];
    ld_nxt   = start;
    mul_nxt  = ld_r;
    done_nxt = mul_r;
    neg_nxt  = neg_r;
    mag_nxt  = mag_r;
    if (start) begin
      neg_nxt = dividend[SUM_W-1];
      mag_nxt = abs_w[MAG_W-1:0] + HALF;
    end
    prod_nxt = PROD_W'(mag_r) * PROD_W'(RECIP);
    quot_nxt = quot_r;
    if (mul_r) begin
      quot_nxt = neg_r ? rate_t'(-qs_w) : rate_t'(qs_w);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ld_r   <= 1'b0;
      mul_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      ld_r   <= ld_nxt;
      mul_r  <= mul_nxt;
      done_r <= done_nxt;
    end
    neg_r  <= neg_nxt;
    mag_r  <= mag_nxt;
    prod_r <= prod_nxt;
    quot_r <= quot_nxt;
  end

endmodule

### src/gyro_offset_calibrate_smooth.sv
`timescale 1ns / 1ps
// Three-axis gyro rate conditioner with offset calibration and smoothing.
// Input words: in_tdata carries raw x, y, z (signed 16 bits each); in_tuser
// is the command flag, 1 starting a calibration run (sample ignored).
// Result words: one per input word, three Q8 deg/s rates in out_tdata and
// the calibrating / calibration-done flags in out_tuser.
// Configuration: cfg_index 0 writes alpha (Q1.16), 1 writes settle_limit.
// A smoothed sample passes through the scale and the smoothing multiply for
// each axis, a calibration sample only the scale multiply, a command neither.
// The last summed sample of a run adds three passes of the reciprocal divider.
// All per-axis multiplies share one 18x23 multiplier.
// One word is in work at a time; in_tready is high only between words.
// A result waits in the output register while out_tready is low; the next
// word is accepted meanwhile and its result is held back until the
// register frees.
// Reset (rst_n low, synchronous) clears rates, offsets, sums and flags and
// loads alpha = 6554 and settle_limit = 448.
module gyro_offset_calibrate_smooth #(
  parameter int CAL_SAMPLES = 25
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // raw_x, raw_y, raw_z
  input  logic [0:0]  in_tuser,   // command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // rate_x, rate_y, rate_z, zero pad
  output logic [1:0]  out_tuser,  // calibrating, calibration_done
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [16:0] cfg_wdata
);
  import gocs_pkg::*;

  localparam int CNT_W = $clog2(CAL_SAMPLES + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAL_SAMPLES);

  typedef enum logic [2:0] {
    S_IDLE, S_SCALE, S_SCWB, S_SMUL, S_SMWB, S_DIV, S_DIVW, S_FIN
  } state_t;

  state_t               state_r, state_nxt;
  axis_t                ax_r, ax_nxt;
  logic [RAW_W-1:0]     raw_r [NUM_AX];
  logic [RAW_W-1:0]     raw_nxt [NUM_AX];
  rate_t                rate_r [NUM_AX];
  rate_t                rate_nxt [NUM_AX];
  rate_t                off_r [NUM_AX];
  rate_t                off_nxt [NUM_AX];
  sum_t                 sum_r [NUM_AX];
  sum_t                 sum_nxt [NUM_AX];
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 incal_r, incal_nxt;
  logic                 await_r, await_nxt;
  logic                 fail_r, fail_nxt;
  logic                 done_r, done_nxt;
  mul_b_t               diff_r, diff_nxt;
  logic [ALPHA_W-1:0]   alpha_r, alpha_nxt;
  logic [LIM_W-1:0]     lim_r, lim_nxt;
  logic                 ovalid_r, ovalid_nxt;
  logic [63:0]          odata_r, odata_nxt;
  logic [1:0]           ouser_r, ouser_nxt;

  mul_a_t               mul_a;
  mul_b_t               mul_b;
  prod_t                mul_p;
  logic                 div_start;
  logic                 div_done;
  rate_t                div_q;

  rate_t                s_w;
  logic [ALPHA_W-1:0]   alpha_sat;
  logic signed [RATE_W:0] dev_w;
  logic signed [RATE_W:0] lim_w;
  logic                 fail_w;
  logic signed [P_W-17:0] step_w;
  sum_t                 upd_w;
  logic [CNT_W-1:0]     cnt_inc;

  gocs_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (mul_p)
  );

  gocs_rdiv #(.DIVISOR(CAL_SAMPLES)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r[ax_r]),
    .done_r   (div_done),
    .quot_r   (div_q)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign out_tuser  = ouser_r;

  always_comb begin
    alpha_sat = (alpha_r > ALPHA_ONE) ? ALPHA_ONE : alpha_r;
    s_w       = rate_t'(mul_p[28:8]);
    dev_w     = (RATE_W + 1)'(s_w) - (RATE_W + 1)'(off_r[0]);
    lim_w     = (RATE_W + 1)'($signed({1'b0, lim_r}));
    fail_w    = (dev_w > lim_w) || (dev_w < -lim_w);
    step_w    = $signed(mul_p[P_W-1:16]);
    upd_w     = SUM_W'(rate_r[ax_r]) + SUM_W'(step_w);
    cnt_inc   = cnt_r + 1'b1;
  end

  always_comb begin
    state_nxt  = state_r;
    ax_nxt     = ax_r;
    raw_nxt    = raw_r;
    rate_nxt   = rate_r;
    off_nxt    = off_r;
    sum_nxt    = sum_r;
    cnt_nxt    = cnt_r;
    incal_nxt  = incal_r;
    await_nxt  = await_r;
    fail_nxt   = fail_r;
    done_nxt   = done_r;
    diff_nxt   = diff_r;
    alpha_nxt  = alpha_r;
    lim_nxt    = lim_r;
    ovalid_nxt = ovalid_r & ~out_tready;
    odata_nxt  = odata_r;
    ouser_nxt  = ouser_r;
    mul_a      = SCALE_MUL;
    mul_b      = MB_W'($signed(raw_r[ax_r]));
    div_start  = 1'b0;

    if (cfg_we) begin
      unique case (cfg_index[0])
        REG_ALPHA: alpha_nxt = cfg_wdata;
        REG_LIMIT: lim_nxt   = cfg_wdata[LIM_W-1:0];
        default:   alpha_nxt = alpha_r;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          raw_nxt[0] = in_tdata[15:0];
          raw_nxt[1] = in_tdata[31:16];
          raw_nxt[2] = in_tdata[47:32];
          ax_nxt     = AX_FIRST;
          done_nxt   = 1'b0;
          fail_nxt   = 1'b0;
          if (in_tuser[0]) begin
            incal_nxt = 1'b1;
            await_nxt = 1'b0;
            cnt_nxt   = '0;
            for (int i = 0; i < NUM_AX; i++) begin
              sum_nxt[i] = '0;
              off_nxt[i] = '0;
            end
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_SCALE;
          end
        end
      end
      S_SCALE: begin
        state_nxt = S_SCWB;
      end
      S_SCWB: begin
        if (!incal_r) begin
          diff_nxt  = MB_W'(s_w) - MB_W'(off_r[ax_r]) - MB_W'(rate_r[ax_r]);
          state_nxt = S_SMUL;
        end else begin
          rate_nxt[ax_r] = s_w;
          if (!await_r) begin
            sum_nxt[ax_r] = sum_r[ax_r] + SUM_W'(s_w);
          end else if (ax_r == AX_FIRST) begin
            fail_nxt = fail_w;
          end
          if (ax_r != AX_LAST) begin
            ax_nxt    = ax_r + 1'b1;
            state_nxt = S_SCALE;
          end else if (!await_r) begin
            cnt_nxt = cnt_inc;
            if (cnt_inc >= CNT_FULL) begin
              ax_nxt    = AX_FIRST;
              state_nxt = S_DIV;
            end else begin
              state_nxt = S_FIN;
            end
          end else begin
            state_nxt = S_FIN;
            cnt_nxt   = '0;
            await_nxt = 1'b0;
            if (fail_r) begin
              for (int i = 0; i < NUM_AX; i++) begin
                sum_nxt[i] = '0;
                off_nxt[i] = '0;
              end
            end else begin
              incal_nxt = 1'b0;
              done_nxt  = 1'b1;
            end
          end
        end
      end
      S_SMUL: begin
        mul_a     = mul_a_t'({1'b0, alpha_sat});
        mul_b     = diff_r;
        state_nxt = S_SMWB;
      end
      S_SMWB: begin
        if (upd_w > SUM_W'(RATE_MAX)) begin
          rate_nxt[ax_r] = RATE_MAX;
        end else if (upd_w < SUM_W'(RATE_MIN)) begin
          rate_nxt[ax_r] = RATE_MIN;
        end else begin
          rate_nxt[ax_r] = rate_t'(upd_w);
        end
        if (ax_r == AX_LAST) begin
          state_nxt = S_FIN;
        end else begin
          ax_nxt    = ax_r + 1'b1;
          state_nxt = S_SCALE;
        end
      end
      S_DIV: begin
        div_start = 1'b1;
        state_nxt = S_DIVW;
      end
      S_DIVW: begin
        if (div_done) begin
          off_nxt[ax_r] = div_q;
          if (ax_r == AX_LAST) begin
            await_nxt = 1'b1;
            state_nxt = S_FIN;
          end else begin
            ax_nxt    = ax_r + 1'b1;
            state_nxt = S_DIV;
          end
        end
      end
      S_FIN: begin
        if (!ovalid_r || out_tready) begin
          ovalid_nxt = 1'b1;
          odata_nxt  = {1'b0, rate_r[2], rate_r[1], rate_r[0]};
          ouser_nxt  = {done_r, incal_r};
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ax_r     <= AX_FIRST;
      cnt_r    <= '0;
      incal_r  <= 1'b0;
      await_r  <= 1'b0;
      fail_r   <= 1'b0;
      done_r   <= 1'b0;
      alpha_r  <= ALPHA_RST;
      lim_r    <= LIM_RST;
      ovalid_r <= 1'b0;
      for (int i = 0; i < NUM_AX; i++) begin
        rate_r[i] <= '0;
        off_r[i]  <= '0;
        sum_r[i]  <= '0;
      end
    end else begin
      state_r  <= state_nxt;
      ax_r     <= ax_nxt;
      cnt_r    <= cnt_nxt;
      incal_r  <= incal_nxt;
      await_r  <= await_nxt;
      fail_r   <= fail_nxt;
      done_r   <= done_nxt;
      alpha_r  <= alpha_nxt;
      lim_r    <= lim_nxt;
      ovalid_r <= ovalid_nxt;
      rate_r   <= rate_nxt;
      off_r    <= off_nxt;
      sum_r    <= sum_nxt;
    end
    raw_r   <= raw_nxt;
    diff_r  <= diff_nxt;
    odata_r <= odata_nxt;
    ouser_r <= ouser_nxt;
  end

endmodule

### dv/gyro_rate_checker.sv
`timescale 1ns / 1ps

module gyro_rate_checker #(
  parameter int CAL_SAMPLES = 25
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [47:0] in_tdata,   // raw_x, raw_y, raw_z
  input  logic [0:0]  in_tuser,   // command
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [63:0] out_tdata,  // rate_x, rate_y, rate_z, zero pad
  input  logic [1:0]  out_tuser,  // calibrating, calibration_done
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [16:0] cfg_wdata,
  output int          mismatches,
  output int          pending_words
);
  import gocs_pkg::*;

  typedef struct packed {
    logic  done;
    logic  calibrating;
    rate_t z;
    rate_t y;
    rate_t x;
  } rate_word_t;

  rate_word_t expected_rates [$];

  longint alpha_q;
  longint limit_q;
  longint smooth_rate [NUM_AX];
  longint axis_offset [NUM_AX];
  longint cal_sum [NUM_AX];
  int     cal_count;
  bit     calibrating_q;
  bit     checking_q;
  int     error_count = 0;

  function automatic void restart_offsets();
    for (int i = 0; i < NUM_AX; i++) begin
      cal_sum[i] = 0;
      axis_offset[i] = 0;
    end
    cal_count = 0;
    checking_q = 1'b0;
  endfunction

  function automatic rate_word_t advance_gyro(logic cmd, logic [47:0] raw);
    rate_word_t         w;
    logic signed [15:0] r;
    longint             s [NUM_AX];
    longint             a;
    longint             diff;
    longint             dev;
    longint             nxt;
    w = '0;
    if (cmd) begin
      calibrating_q = 1'b1;
      restart_offsets();
    end else begin
      for (int i = 0; i < NUM_AX; i++) begin
        r = raw[16*i +: 16];
        s[i] = (longint'(r) * longint'(SCALE_MUL)) >>> 8;
      end
      if (calibrating_q) begin
        for (int i = 0; i < NUM_AX; i++) smooth_rate[i] = s[i];
        if (!checking_q) begin
          for (int i = 0; i < NUM_AX; i++) cal_sum[i] += s[i];
          cal_count++;
          if (cal_count >= CAL_SAMPLES) begin
            for (int i = 0; i < NUM_AX; i++) begin
              axis_offset[i] = (cal_sum[i] >= 0) ?
                  (cal_sum[i] + CAL_SAMPLES / 2) / CAL_SAMPLES :
                  -((-cal_sum[i] + CAL_SAMPLES / 2) / CAL_SAMPLES);
            end
            checking_q = 1'b1;
          end
        end else begin
          dev = s[0] - axis_offset[0];
          if (dev > limit_q || dev < -limit_q) begin
            restart_offsets();
          end else begin
            calibrating_q = 1'b0;
            checking_q = 1'b0;
            cal_count = 0;
            w.done = 1'b1;
          end
        end
      end else begin
        a = (alpha_q > longint'(ALPHA_ONE)) ? longint'(ALPHA_ONE) : alpha_q;
        for (int i = 0; i < NUM_AX; i++) begin
          diff = s[i] - axis_offset[i] - smooth_rate[i];
          nxt = smooth_rate[i] + ((a * diff) >>> 16);
          if (nxt > longint'(RATE_MAX)) nxt = longint'(RATE_MAX);
          if (nxt < longint'(RATE_MIN)) nxt = longint'(RATE_MIN);
          smooth_rate[i] = nxt;
        end
      end
    end
    w.x = rate_t'(smooth_rate[0]);
    w.y = rate_t'(smooth_rate[1]);
    w.z = rate_t'(smooth_rate[2]);
    w.calibrating = calibrating_q;
    return w;
  endfunction

  always @(posedge clk) begin
    rate_word_t got;
    rate_word_t want;
    if (!rst_n) begin
      alpha_q = longint'(ALPHA_RST);
      limit_q = longint'(LIM_RST);
      for (int i = 0; i < NUM_AX; i++) smooth_rate[i] = 0;
      restart_offsets();
      calibrating_q = 1'b0;
      expected_rates.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_ALPHA) alpha_q = longint'(cfg_wdata);
        else                        limit_q = longint'(cfg_wdata[15:0]);
      end
      if (in_tvalid && in_tready) begin
        expected_rates.push_back(advance_gyro(in_tuser[0], in_tdata));
      end
      if (out_tvalid && out_tready) begin
        got.x = out_tdata[20:0];
        got.y = out_tdata[41:21];
        got.z = out_tdata[62:42];
        got.calibrating = out_tuser[0];
        got.done = out_tuser[1];
        if (expected_rates.size() == 0) begin
          error_count++;
          if (error_count <= 10)
            $display("unexpected word: x=%0d y=%0d z=%0d cal=%0b done=%0b",
                     $signed(got.x), $signed(got.y), $signed(got.z),
                     got.calibrating, got.done);
        end else begin
          want = expected_rates.pop_front();
          if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
              got.calibrating !== want.calibrating || got.done !== want.done) begin
            error_count++;
            if (error_count <= 10)
              $display({"word mismatch: expected x=%0d y=%0d z=%0d cal=%0b done=%0b,",
                        " got x=%0d y=%0d z=%0d cal=%0b done=%0b"},
                       $signed(want.x), $signed(want.y), $signed(want.z),
                       want.calibrating, want.done,
                       $signed(got.x), $signed(got.y), $signed(got.z),
                       got.calibrating, got.done);
          end
        end
      end
    end
    mismatches <= error_count;
    pending_words <= expected_rates.size();
  end

endmodule

### dv/tb_gyro_offset_calibrate_smooth.sv
`timescale 1ns / 1ps

module tb_gyro_offset_calibrate_smooth;
  import gocs_pkg::*;

  localparam int CAL_RUN     = 25;
  localparam int ITEMS       = 750;
  localparam int QUIET_TAIL  = 80;
  localparam int LONG_HOLD   = 400;
  localparam int DRAIN       = 120;
  localparam int CYCLE_LIMIT = 1_000_000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;   // raw_x, raw_y, raw_z
  logic [0:0]  in_tuser;   // command
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;  // rate_x, rate_y, rate_z, zero pad
  logic [1:0]  out_tuser;  // calibrating, calibration_done
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [16:0] cfg_wdata;

  int mismatches;
  int pending_words;
  int sent = 0;
  int cycle_count = 0;
  bit quiet = 1'b0;
  bit stall_req = 1'b0;

  gyro_offset_calibrate_smooth #(
    .CAL_SAMPLES(CAL_RUN)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  gyro_rate_checker #(
    .CAL_SAMPLES(CAL_RUN)
  ) rate_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .mismatches    (mismatches),
    .pending_words (pending_words)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // receiver: random stalls, one long hold on request
  initial begin
    out_tready = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (stall_req) begin
        stall_req = 1'b0;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  function automatic longint scaled_q8(logic signed [15:0] r);
    return (longint'(r) * longint'(SCALE_MUL)) >>> 8;
  endfunction

  function automatic logic signed [15:0] near(logic signed [15:0] base, int spread);
    longint v;
    v = longint'(base) + longint'($urandom_range(0, 2 * spread)) - spread;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return 16'(v);
  endfunction

  function automatic logic signed [15:0] pick_base();
    case ($urandom_range(0, 4))
      0:       return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      1:       return 16'($urandom);
      default: return 16'($urandom_range(0, 400)) - 16'sd200;
    endcase
  endfunction

  task automatic send_word(input logic cmd, input logic signed [15:0] x, y, z);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {z, y, x};
    do @(posedge clk); while (!in_tready);
    sent++;
    if (sent >= ITEMS - QUIET_TAIL) quiet = 1'b1;
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
  endtask

  task automatic set_regs(input logic [16:0] alpha_v, input logic [15:0] limit_v);
    cfg_we    <= 1'b1;
    cfg_index <= REG_ALPHA;
    cfg_wdata <= alpha_v;
    @(posedge clk);
    cfg_index <= REG_LIMIT;
    cfg_wdata <= {1'b0, limit_v};
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // one well-formed calibration run planned ahead, so the check
  // deviation can be placed on or just past the limit
  task automatic run_calibration(input bit stress, input bit hold_output);
    logic signed [15:0] cal_x [CAL_RUN];
    logic signed [15:0] cal_y [CAL_RUN];
    logic signed [15:0] cal_z [CAL_RUN];
    logic signed [15:0] bx, by, bz, chk, best;
    logic [16:0]        alpha_v;
    logic [15:0]        limit_v;
    int                 spread;
    longint             total, offset_x, dev, gap, best_gap;
    bit                 fails;

    spread = ($urandom_range(0, 3) == 0) ? 3000 : 25;
    bx = pick_base();
    by = pick_base();
    bz = pick_base();
    if (stress) begin
      spread = 0;
      bx = 16'sh8000;
      by = 16'sh8000;
      bz = 16'sh7FFF;
    end
    total = 0;
    best = 16'sh0000;
    for (int i = 0; i < CAL_RUN; i++) begin
      cal_x[i] = near(bx, spread);
      cal_y[i] = near(by, spread);
      cal_z[i] = near(bz, spread);
      total += scaled_q8(cal_x[i]);
    end
    offset_x = (total >= 0) ? (total + CAL_RUN / 2) / CAL_RUN :
                              -((-total + CAL_RUN / 2) / CAL_RUN);
    best_gap = 64'sd1 << 40;
    for (int i = 0; i < CAL_RUN; i++) begin
      gap = scaled_q8(cal_x[i]) - offset_x;
      if (gap < 0) gap = -gap;
      if (gap < best_gap) begin
        best_gap = gap;
        best = cal_x[i];
      end
    end
    chk = ($urandom_range(0, 4) == 0) ? 16'($urandom) : near(bx, spread);
    dev = scaled_q8(chk) - offset_x;
    if (dev < 0) dev = -dev;

    case ($urandom_range(0, 3))
      0: limit_v = (dev > 65535) ? 16'hFFFF : 16'(dev);
      1: limit_v = (dev > 0 && dev <= 65536) ? 16'(dev - 1) : 16'($urandom);
      2: limit_v = $urandom_range(0, 2) == 0 ? 16'($urandom) :
                   ($urandom_range(0, 1) ? 16'hFFFF : 16'h0000);
      default: limit_v = 16'($urandom_range(0, 2000));
    endcase
    fails = dev > longint'(limit_v);

    case ($urandom_range(0, 5))
      0:       alpha_v = '0;
      1:       alpha_v = ALPHA_ONE;
      2:       alpha_v = 17'h1FFFF;
      3:       alpha_v = ALPHA_RST;
      default: alpha_v = 17'($urandom_range(0, 131071));
    endcase
    if (stress) alpha_v = ALPHA_ONE;

    wait_idle();
    set_regs(alpha_v, limit_v);

    send_word(1'b1, 16'($urandom), 16'($urandom), 16'($urandom));
    if (!stress && $urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, CAL_RUN + 1))
        send_word(1'b0, 16'($urandom), 16'($urandom), 16'($urandom));
      send_word(1'b1, 16'($urandom), 16'($urandom), 16'($urandom));
    end
    for (int i = 0; i < CAL_RUN; i++) send_word(1'b0, cal_x[i], cal_y[i], cal_z[i]);
    send_word(1'b0, chk, near(by, spread), near(bz, spread));
    if (fails) begin
      // repeat the run with the sample closest to the new offset as check
      for (int i = 0; i < CAL_RUN; i++) send_word(1'b0, cal_x[i], cal_y[i], cal_z[i]);
      send_word(1'b0, best, near(by, spread), near(bz, spread));
    end

    if (hold_output) stall_req = 1'b1;
    repeat ($urandom_range(3, 15)) begin
      case (stress ? 1 : $urandom_range(0, 3))
        0: send_word(1'b0, 16'($urandom), 16'($urandom), 16'($urandom));
        1: send_word(1'b0, bx[15] ? 16'sh7FFF : 16'sh8000,
                     by[15] ? 16'sh7FFF : 16'sh8000,
                     bz[15] ? 16'sh7FFF : 16'sh8000);
        default: send_word(1'b0, near(bx, spread), near(by, spread), near(bz, spread));
      endcase
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    cfg_we    = 1'b0;
    cfg_index = REG_ALPHA;
    cfg_wdata = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    send_word(1'b0, 16'sh0000, 16'sh0000, 16'sh0000);
    send_word(1'b0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_word(1'b0, 16'sh8000, 16'sh8000, 16'sh8000);
    send_word(1'b0, 16'sh7FFF, 16'sh8000, 16'shFFFF);
    send_word(1'b0, 16'shFFFF, 16'sh0001, 16'sh8000);
    send_word(1'b0, 16'sh5555, 16'shAAAA, 16'sh5555);
    send_word(1'b0, 16'shAAAA, 16'sh5555, 16'shAAAA);
    send_word(1'b1, 16'shFFFF, 16'shFFFF, 16'shFFFF);
    send_word(1'b0, 16'sd100, -16'sd100, 16'sd7);
    send_word(1'b0, 16'sd101, -16'sd99, 16'sd6);
    send_word(1'b0, 16'sh7FFF, 16'sh8000, 16'sh0000);
    send_word(1'b1, 16'sh0000, 16'sh0000, 16'sh0000);
    send_word(1'b0, -16'sd3, 16'sd2, 16'sd1);
    send_word(1'b0, 16'sh8000, 16'sh7FFF, 16'sh8000);

    run_calibration(1'b1, 1'b0);
    for (int run = 1; sent < ITEMS; run++) run_calibration(1'b0, run == 2);

    wait_idle();
    repeat (DRAIN) @(posedge clk);
    if (mismatches == 0) $display("PASS");
    else                 $display("FAIL");
    $finish;
  end

endmodule
